// ===== sv/random_walk_grid_carver_unit_macros.svh =====
// assertion macros of the random walk grid carver control module
`ifndef RANDOM_WALK_GRID_CARVER_UNIT_MACROS_SVH
`define RANDOM_WALK_GRID_CARVER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle property under the async active-low reset
`define RWGC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// antecedent in one cycle, consequent in the next
`define RWGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RWGC_ASSERT(lbl, clk, rst_n, prop, msg)
`define RWGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== sv/rwgc_pkg.sv =====
// types, constants and helpers of the random walk grid carver
package rwgc_pkg;

	// map geometry
	localparam int MAX_ROWS  = 32;
	localparam int MAX_COLS  = 64;
	localparam int ROW_W     = 5;
	localparam int COL_W     = 6;
	localparam int ROWN_W    = 6;
	localparam int COLN_W    = 7;
	localparam int MAP_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);

	// configuration register widths and reset values
	localparam int ROWS_CFG_W = 6;
	localparam int COLS_CFG_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam logic [ROWS_CFG_W-1:0] ROWS_RST = ROWS_CFG_W'(30);
	localparam logic [COLS_CFG_W-1:0] COLS_RST = COLS_CFG_W'(50);

	// item fields
	localparam int FUNC_W    = 2;
	localparam int DIR_BITS  = 2;
	localparam int CNT_W     = 12;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USED_W = ROW_W + COL_W + 1 + CNT_W + 1 + 1;

	// epoch tags in the map: a cell is floor when its tag equals the current epoch
	localparam int EPOCH_W = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_CLR  = {EPOCH_W{1'b1}};
	localparam logic [EPOCH_W-1:0] EPOCH_LAST = EPOCH_CLR - EPOCH_W'(1);

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(1);

	typedef enum logic [FUNC_W-1:0] {
		FUNC_RESTART = 2'd0,
		FUNC_MOVE    = 2'd1,
		FUNC_READ    = 2'd2,
		FUNC_NOP     = 2'd3
	} func_t;

	typedef enum logic [DIR_BITS-1:0] {
		DIR_N = 2'd0,
		DIR_E = 2'd1,
		DIR_S = 2'd2,
		DIR_W = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'd0,
		ST_IDLE  = 2'd1,
		ST_EXEC  = 2'd2
	} state_t;

	// map memory access
	typedef struct packed {
		logic              we;
		logic [MAP_AW-1:0] waddr;
		logic [EPOCH_W-1:0] wdata;
		logic              re;
		logic [MAP_AW-1:0] raddr;
	} mem_req_t;

	// grid size in use
	typedef struct packed {
		logic [ROWN_W-1:0] rows;
		logic [COLN_W-1:0] cols;
		logic [CNT_W-1:0]  half;
	} grid_cfg_t;

	function automatic logic [MAP_AW-1:0] map_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		map_addr = MAP_AW'(MAP_AW'(row) * MAP_AW'(MAX_COLS) + MAP_AW'(col));
	endfunction

endpackage

// ===== sv/rwgc_map_mem.sv =====
// map memory: one epoch tag per cell, one write and one registered read port
module rwgc_map_mem (
	input  logic                      clk,
	input  rwgc_pkg::mem_req_t        req,
	output logic [rwgc_pkg::EPOCH_W-1:0] rdata
);
	import rwgc_pkg::*;

	logic [EPOCH_W-1:0] tag_mem [MAP_DEPTH];
	logic [EPOCH_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			tag_mem[req.waddr] <= req.wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= tag_mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/rwgc_ctrl.sv =====
// walker control: item decode, map read-modify-write, clearing sweep, result register
`include "random_walk_grid_carver_unit_macros.svh"

module rwgc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rwgc_pkg::grid_cfg_t           grid,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// direction[1:0], pick_row[6:2], pick_col[12:7], zero fill
	input  logic [rwgc_pkg::IN_DATA_W-1:0] s_tdata,
	// func[1:0]
	input  logic [rwgc_pkg::FUNC_W-1:0]   s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// walker_row[4:0], walker_col[10:5], carved[11], floor_total[23:12],
	// finished[24], cell_is_floor[25], zero fill
	output logic [rwgc_pkg::OUT_DATA_W-1:0] m_tdata,
	output rwgc_pkg::mem_req_t            mem_req,
	input  logic [rwgc_pkg::EPOCH_W-1:0]  mem_rdata
);
	import rwgc_pkg::*;

	state_t state_q, state_d;
	logic [MAP_AW-1:0]  clr_cnt_q;
	logic               pend_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [ROW_W-1:0]   pos_row_q;
	logic [COL_W-1:0]   pos_col_q;
	logic [CNT_W-1:0]   count_q;

	// item in flight
	func_t              func_s1;
	logic               ok_s1;
	logic               inrange_s1;
	logic [ROW_W-1:0]   nr_s1;
	logic [COL_W-1:0]   nc_s1;
	logic [MAP_AW-1:0]  addr_s1;

	// result register
	logic               out_valid_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [COL_W-1:0]   out_col_q;
	logic               out_carved_q;
	logic [CNT_W-1:0]   out_count_q;
	logic               out_fin_q;
	logic               out_cell_q;

	// input decode
	func_t             in_func;
	dir_t              in_dir;
	logic [ROW_W-1:0]  in_prow;
	logic [COL_W-1:0]  in_pcol;
	logic              accept;
	logic              restart_wrap;
	logic              clr_last;

	always_comb begin
		in_func      = func_t'(s_tuser);
		in_dir       = dir_t'(s_tdata[DIR_BITS-1:0]);
		in_prow      = s_tdata[DIR_BITS +: ROW_W];
		in_pcol      = s_tdata[DIR_BITS+ROW_W +: COL_W];
		accept       = s_tvalid && s_tready;
		restart_wrap = (in_func == FUNC_RESTART) && (epoch_q == EPOCH_LAST);
		clr_last     = (clr_cnt_q == MAP_AW'(MAP_DEPTH - 1));
	end

	// move target and bounds on the axis that changes
	logic [ROWN_W:0]  row_ext;
	logic [COLN_W:0]  col_ext;
	logic [ROWN_W:0]  rows_ext;
	logic [COLN_W:0]  cols_ext;
	logic             done_now;
	logic             mv_ok;
	logic [ROW_W-1:0] mv_row;
	logic [COL_W-1:0] mv_col;

	always_comb begin
		row_ext  = (ROWN_W+1)'(pos_row_q);
		col_ext  = (COLN_W+1)'(pos_col_q);
		rows_ext = (ROWN_W+1)'(grid.rows);
		cols_ext = (COLN_W+1)'(grid.cols);
		done_now = (count_q >= grid.half);
		mv_row   = pos_row_q;
		mv_col   = pos_col_q;
		mv_ok    = 1'b0;
		case (in_dir)
			DIR_N: begin
				mv_ok  = (row_ext >= (ROWN_W+1)'(2)) && (row_ext + (ROWN_W+1)'(1) <= rows_ext);
				mv_row = pos_row_q - ROW_W'(1);
			end
			DIR_S: begin
				mv_ok  = (row_ext + (ROWN_W+1)'(3) <= rows_ext);
				mv_row = pos_row_q + ROW_W'(1);
			end
			DIR_E: begin
				mv_ok  = (col_ext + (COLN_W+1)'(3) <= cols_ext);
				mv_col = pos_col_q + COL_W'(1);
			end
			DIR_W: begin
				mv_ok  = (col_ext >= (COLN_W+1)'(2)) && (col_ext + (COLN_W+1)'(1) <= cols_ext);
				mv_col = pos_col_q - COL_W'(1);
			end
			default: begin
				mv_ok = 1'b0;
			end
		endcase
		mv_ok = mv_ok && !done_now;
	end

	// restart cell, saturated to the grid in use
	logic [ROW_W-1:0] rs_row;
	logic [COL_W-1:0] rs_col;
	logic             rd_inrange;

	always_comb begin
		if (grid.rows == '0) begin
			rs_row = '0;
		end else if (ROWN_W'(in_prow) >= grid.rows) begin
			rs_row = ROW_W'(grid.rows - ROWN_W'(1));
		end else begin
			rs_row = in_prow;
		end
		if (grid.cols == '0) begin
			rs_col = '0;
		end else if (COLN_W'(in_pcol) >= grid.cols) begin
			rs_col = COL_W'(grid.cols - COLN_W'(1));
		end else begin
			rs_col = in_pcol;
		end
		rd_inrange = (ROWN_W'(in_prow) < grid.rows) && (COLN_W'(in_pcol) < grid.cols);
	end

	// execute state: tag compare and new state
	logic             fire;
	logic             floor_hit;
	logic             carve;
	logic [ROW_W-1:0] row_new;
	logic [COL_W-1:0] col_new;
	logic [CNT_W-1:0] count_new;
	logic             cell_new;

	always_comb begin
		fire      = (state_q == ST_EXEC) && (!out_valid_q || m_tready);
		floor_hit = (mem_rdata == epoch_q);
		carve     = 1'b0;
		row_new   = pos_row_q;
		col_new   = pos_col_q;
		count_new = count_q;
		cell_new  = 1'b0;
		case (func_s1)
			FUNC_RESTART: begin
				carve     = 1'b1;
				row_new   = nr_s1;
				col_new   = nc_s1;
				count_new = CNT_W'(1);
			end
			FUNC_MOVE: begin
				if (ok_s1) begin
					row_new = nr_s1;
					col_new = nc_s1;
					if (!floor_hit) begin
						carve     = 1'b1;
						count_new = count_q + CNT_W'(1);
					end
				end
			end
			FUNC_READ: begin
				cell_new = inrange_s1 && floor_hit;
			end
			default: begin
				carve = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = pend_q ? ST_EXEC : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = restart_wrap ? ST_CLEAR : ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (fire) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// handshake and memory port
	always_comb begin
		s_tready      = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = addr_s1;
		mem_req.wdata = epoch_q;
		mem_req.re    = 1'b0;
		mem_req.raddr = (in_func == FUNC_READ) ? map_addr(in_prow, in_pcol)
		                                       : map_addr(mv_row, mv_col);
		case (state_q)
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_cnt_q;
				mem_req.wdata = EPOCH_CLR;
			end
			ST_IDLE: begin
				s_tready   = 1'b1;
				mem_req.re = s_tvalid && ((in_func == FUNC_MOVE) || (in_func == FUNC_READ));
			end
			ST_EXEC: begin
				mem_req.we = fire && carve;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			pend_q    <= 1'b0;
			epoch_q   <= '0;
			pos_row_q <= '0;
			pos_col_q <= '0;
			count_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + MAP_AW'(1);
				if (clr_last) begin
					epoch_q <= '0;
					pend_q  <= 1'b0;
				end
			end
			if (accept && (in_func == FUNC_RESTART)) begin
				if (restart_wrap) begin
					pend_q <= 1'b1;
				end else begin
					epoch_q <= epoch_q + EPOCH_W'(1);
				end
			end
			if (fire) begin
				pos_row_q <= row_new;
				pos_col_q <= col_new;
				count_q   <= count_new;
			end
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1    <= in_func;
			ok_s1      <= mv_ok;
			inrange_s1 <= rd_inrange;
			nr_s1      <= (in_func == FUNC_RESTART) ? rs_row : mv_row;
			nc_s1      <= (in_func == FUNC_RESTART) ? rs_col : mv_col;
			addr_s1    <= (in_func == FUNC_RESTART) ? map_addr(rs_row, rs_col)
			                                        : map_addr(mv_row, mv_col);
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			out_row_q    <= row_new;
			out_col_q    <= col_new;
			out_carved_q <= carve;
			out_count_q  <= count_new;
			out_fin_q    <= (count_new >= grid.half);
			out_cell_q   <= cell_new;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W-OUT_USED_W)'(0), out_cell_q, out_fin_q, out_count_q,
	                   out_carved_q, out_col_q, out_row_q};

	// map writes never share a cycle with an accepted item
	`RWGC_ASSERT(a_no_write_on_accept, clk, arst_n, mem_req.we |-> !accept, "map write during accept")
	// floor count only changes on a carve or a restart
	`RWGC_ASSERT_NEXT(a_count_hold, clk, arst_n, !(fire && carve), $stable(count_q), "floor count changed without a carve")
	// a result appears only after an item completed
	`RWGC_ASSERT(a_result_source, clk, arst_n, $rose(out_valid_q) |-> $past(fire), "result without completed item")

endmodule

// ===== sv/random_walk_grid_carver_unit.sv =====
// Random walk grid carver: top level with grid size registers.
// An accepted item is captured, then compared in the execute state, which loads the result
// register and waits while the output is held. Each item reads then writes one map cell, so no
// new item is taken before the last is done. Every 255th restart first sweeps all 2048 cells.
// Reset (arst_n, asynchronous, active low) starts a clearing sweep over all 2048 map cells;
// no item is accepted until it ends, configuration writes are taken throughout.
module random_walk_grid_carver_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rwgc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rwgc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// direction[1:0], pick_row[6:2], pick_col[12:7], zero fill
	input  logic [rwgc_pkg::IN_DATA_W-1:0]   s_tdata,
	// func[1:0]
	input  logic [rwgc_pkg::FUNC_W-1:0]      s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// walker_row[4:0], walker_col[10:5], carved[11], floor_total[23:12],
	// finished[24], cell_is_floor[25], zero fill
	output logic [rwgc_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import rwgc_pkg::*;

	logic [ROWS_CFG_W-1:0] rows_q;
	logic [COLS_CFG_W-1:0] cols_q;
	grid_cfg_t             grid;
	mem_req_t              mem_req;
	logic [EPOCH_W-1:0]    mem_rdata;
	logic [ROWN_W+COLN_W-1:0] area;

	assign cfg_ready = 1'b1;

	// grid size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RST;
			cols_q <= COLS_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_ROWS) begin
				rows_q <= cfg_data[ROWS_CFG_W-1:0];
			end else if (cfg_index == CFG_COLS) begin
				cols_q <= cfg_data[COLS_CFG_W-1:0];
			end
		end
	end

	// sizes in use, saturated to the map, and the done threshold
	always_comb begin
		grid.rows = (int'(rows_q) > MAX_ROWS) ? ROWN_W'(MAX_ROWS) : ROWN_W'(rows_q);
		grid.cols = (int'(cols_q) > MAX_COLS) ? COLN_W'(MAX_COLS) : COLN_W'(cols_q);
		area      = (ROWN_W+COLN_W)'(grid.rows) * (ROWN_W+COLN_W)'(grid.cols);
		grid.half = CNT_W'(area >> 1);
	end

	rwgc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.grid     (grid),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.mem_req  (mem_req),
		.mem_rdata(mem_rdata)
	);

	rwgc_map_mem u_map (
		.clk  (clk),
		.req  (mem_req),
		.rdata(mem_rdata)
	);

endmodule

// ===== dv/tb.sv =====
// self-checking testbench of the random walk grid carver unit
`timescale 1ns / 100ps

import rwgc_pkg::*;

// one result item as it sits in m_tdata, lowest field last
typedef struct packed {
	logic        cell_is_floor;
	logic        finished;
	logic [11:0] floor_total;
	logic        carved;
	logic [5:0]  walker_col;
	logic [4:0]  walker_row;
} walk_result_t;

// cave map predictor and queue of expected walk results
class carver_scoreboard;
	bit [MAX_COLS-1:0] cave_cells [MAX_ROWS];
	int unsigned walker_r;
	int unsigned walker_c;
	int unsigned floor_cnt;
	int unsigned rows_reg;
	int unsigned cols_reg;
	walk_result_t expected_walks [$];
	int errors;
	int checked;
	int carve_hits;
	int finished_hits;

	function new();
		foreach (cave_cells[r])
			cave_cells[r] = '0;
		walker_r = 0;
		walker_c = 0;
		floor_cnt = 0;
		rows_reg = ROWS_RST;
		cols_reg = COLS_RST;
		errors = 0;
		checked = 0;
		carve_hits = 0;
		finished_hits = 0;
	endfunction

	function void write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		if (idx == CFG_ROWS)
			rows_reg = value[ROWS_CFG_W-1:0];
		else if (idx == CFG_COLS)
			cols_reg = value[COLS_CFG_W-1:0];
	endfunction

	function int unsigned clamp_pick(int unsigned v, int unsigned size);
		if (size == 0)
			return 0;
		return (v >= size) ? size - 1 : v;
	endfunction

	// work out the result of one accepted item and queue it
	function void log_item(func_t f, dir_t d, logic [4:0] pr, logic [5:0] pc);
		int unsigned rows, cols, nr, nc;
		bit ok;
		walk_result_t want;
		rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
		cols = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
		want = '0;
		case (f)
			FUNC_RESTART: begin
				foreach (cave_cells[r])
					cave_cells[r] = '0;
				walker_r = clamp_pick(pr, rows);
				walker_c = clamp_pick(pc, cols);
				cave_cells[walker_r][walker_c] = 1'b1;
				floor_cnt = 1;
				want.carved = 1'b1;
			end
			FUNC_MOVE: begin
				if (floor_cnt < (rows * cols) / 2) begin
					nr = walker_r;
					nc = walker_c;
					// only the coordinate that changes must stay in the interior
					case (d)
						DIR_N: begin
							ok = nr >= 2 && nr + 1 <= rows;
							nr = nr - 1;
						end
						DIR_S: begin
							ok = nr + 3 <= rows;
							nr = nr + 1;
						end
						DIR_E: begin
							ok = nc + 3 <= cols;
							nc = nc + 1;
						end
						default: begin
							ok = nc >= 2 && nc + 1 <= cols;
							nc = nc - 1;
						end
					endcase
					if (ok && nr < MAX_ROWS && nc < MAX_COLS) begin
						walker_r = nr;
						walker_c = nc;
						if (!cave_cells[nr][nc]) begin
							cave_cells[nr][nc] = 1'b1;
							floor_cnt++;
							want.carved = 1'b1;
						end
					end
				end
			end
			FUNC_READ: begin
				if (pr < rows && pc < cols)
					want.cell_is_floor = cave_cells[pr][pc];
			end
			default: ;
		endcase
		want.walker_row = walker_r[4:0];
		want.walker_col = walker_c[5:0];
		want.floor_total = floor_cnt[11:0];
		want.finished = floor_cnt >= (rows * cols) / 2;
		if (want.carved)
			carve_hits++;
		if (want.finished)
			finished_hits++;
		expected_walks.push_back(want);
	endfunction

	function int pending();
		return expected_walks.size();
	endfunction

	function void field_check(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// compare one accepted result item with the oldest expectation
	function void check_result(logic [OUT_DATA_W-1:0] raw);
		walk_result_t got, want;
		got = raw[OUT_USED_W-1:0];
		if (expected_walks.size() == 0) begin
			$display("%0t: unexpected result expected none actual %h", $time, raw);
			errors++;
			return;
		end
		want = expected_walks.pop_front();
		checked++;
		field_check("walker_row", want.walker_row, got.walker_row);
		field_check("walker_col", want.walker_col, got.walker_col);
		field_check("carved", want.carved, got.carved);
		field_check("floor_total", want.floor_total, got.floor_total);
		field_check("finished", want.finished, got.finished);
		field_check("cell_is_floor", want.cell_is_floor, got.cell_is_floor);
	endfunction
endclass

module tb;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [FUNC_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	carver_scoreboard sb;

	int burst_left = 0;
	int n_restart = 0;
	int n_move = 0;
	int n_read = 0;
	int n_nop = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int ready_phase = 0;

	random_walk_grid_carver_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				ready_phase++;
				case ((ready_phase / 48) % 3)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= (ready_phase % 7) < 3;
				endcase
			end
		end
	end

	// result items are checked at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// run limit
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// write both size registers back to back, starting at a falling edge
	task automatic write_sizes(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ROWS;
		cfg_data  <= rows;
		do @(posedge clk); while (!cfg_ready);
		sb.write_size(CFG_ROWS, rows);
		@(negedge clk);
		cfg_index <= CFG_COLS;
		cfg_data  <= cols;
		do @(posedge clk); while (!cfg_ready);
		sb.write_size(CFG_COLS, cols);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// offer one item in bursts with random gaps, return at a falling edge
	task automatic push_item(func_t f, dir_t d, logic [4:0] pr, logic [5:0] pc);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		burst_left--;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {3'b000, pc, pr, d};
		do @(posedge clk); while (!s_tready);
		sb.log_item(f, d, pr, pc);
		case (f)
			FUNC_RESTART: n_restart++;
			FUNC_MOVE:    n_move++;
			FUNC_READ:    n_read++;
			default:      n_nop++;
		endcase
		@(negedge clk);
	endtask

	// stop offering and wait until every expected result has come
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	// a coordinate mostly inside the grid in use, sometimes anywhere
	function automatic int unsigned pick_coord(int unsigned size, int unsigned maxv);
		if (size == 0 || $urandom_range(0, 4) == 0)
			return $urandom_range(0, maxv);
		return $urandom_range(0, ((size > maxv + 1) ? maxv + 1 : size) - 1);
	endfunction

	// one size setting followed by a random walk mix
	task automatic run_phase(logic [CFG_DATA_W-1:0] rows, logic [CFG_DATA_W-1:0] cols,
		int n, int restart_pct, int read_pct, bit long_hold);
		int unsigned er, ec, roll;
		func_t f;
		er = rows[ROWS_CFG_W-1:0];
		ec = cols;
		if (er > MAX_ROWS) er = MAX_ROWS;
		if (ec > MAX_COLS) ec = MAX_COLS;
		write_sizes(rows, cols);
		if (long_hold)
			hold_req = 1'b1;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < restart_pct)
				f = FUNC_RESTART;
			else if (roll < restart_pct + read_pct)
				f = FUNC_READ;
			else if (roll < restart_pct + read_pct + 3)
				f = FUNC_NOP;
			else
				f = FUNC_MOVE;
			if (f == FUNC_MOVE || f == FUNC_NOP)
				push_item(f, dir_t'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
					6'($urandom_range(0, 63)));
			else
				push_item(f, dir_t'($urandom_range(0, 3)), 5'(pick_coord(er, 31)),
					6'(pick_coord(ec, 63)));
		end
		drain();
	endtask

	// stimulus
	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = FUNC_NOP;
		sb = new();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed walk on a 6 x 10 grid
		write_sizes(7'd6, 7'd10);
		push_item(FUNC_READ, DIR_N, 5'd0, 6'd0);
		push_item(FUNC_MOVE, DIR_N, 5'd0, 6'd0);
		// edge row still walks along its own row
		push_item(FUNC_MOVE, DIR_E, 5'd0, 6'd0);
		push_item(FUNC_NOP, DIR_W, 5'd31, 6'd63);
		// start beyond the grid saturates to the last cell
		push_item(FUNC_RESTART, DIR_N, 5'd31, 6'd63);
		push_item(FUNC_MOVE, DIR_W, 5'd0, 6'd0);
		push_item(FUNC_MOVE, DIR_N, 5'd0, 6'd0);
		push_item(FUNC_MOVE, DIR_S, 5'd0, 6'd0);
		push_item(FUNC_MOVE, DIR_E, 5'd0, 6'd0);
		push_item(FUNC_READ, DIR_N, 5'd4, 6'd8);
		push_item(FUNC_READ, DIR_N, 5'd31, 6'd63);
		push_item(FUNC_READ, DIR_N, 5'd5, 6'd9);
		push_item(FUNC_RESTART, DIR_N, 5'd0, 6'd0);
		push_item(FUNC_MOVE, DIR_W, 5'd0, 6'd0);
		push_item(FUNC_MOVE, DIR_S, 5'd0, 6'd0);
		push_item(FUNC_RESTART, DIR_N, 5'd2, 6'd3);
		push_item(FUNC_MOVE, DIR_E, 5'd0, 6'd0);
		// step back onto floor, nothing carved
		push_item(FUNC_MOVE, DIR_W, 5'd0, 6'd0);
		push_item(FUNC_MOVE, DIR_N, 5'd0, 6'd0);
		push_item(FUNC_MOVE, DIR_N, 5'd0, 6'd0);
		push_item(FUNC_READ, DIR_N, 5'd2, 6'd4);
		push_item(FUNC_READ, DIR_N, 5'd0, 6'd0);
		drain();

		// random phases; each keeps the walk of the one before
		run_phase(7'd8, 7'd8, 140, 2, 10, 1'b0);
		run_phase(7'd127, 7'd127, 80, 5, 20, 1'b0);
		run_phase(7'd0, 7'd0, 20, 20, 30, 1'b0);
		run_phase(7'd1, 7'd2, 20, 20, 30, 1'b0);
		run_phase(7'd2, 7'd64, 25, 10, 20, 1'b0);
		run_phase(7'd3, 7'd3, 30, 15, 20, 1'b0);
		run_phase(7'd32, 7'd64, 100, 3, 15, 1'b1);
		// many restarts to wrap the map epoch
		run_phase(7'd5, 7'd6, 280, 95, 3, 1'b0);
		run_phase(7'd30, 7'd50, 40, 5, 15, 1'b0);

		repeat (8) @(negedge clk);
		$display("covered %0d restarts, %0d moves, %0d reads, %0d no-ops over ten grid sizes",
			n_restart, n_move, n_read, n_nop);
		$display("checked %0d results: %0d cells carved, %0d with the walk finished",
			sb.checked, sb.carve_hits, sb.finished_hits);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
